// ===== rtl/pbd_pkg.sv =====
//------------------------------------------------------------------------------
// pbd_pkg: shared constants for the distance constraint core
// Formats, widths and a saturation helper.
//------------------------------------------------------------------------------
package pbd_pkg;

    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned POINT_COUNT_DEF = 65536;
    localparam int unsigned STIFF_W         = 17;
    localparam logic [16:0] STIFF_ONE       = 17'h10000;
    localparam logic [16:0] STIFF_RESET     = 17'h10000;
    localparam int unsigned IDX_W           = 16;
    localparam int unsigned POS_W           = 32;
    localparam int unsigned DIFF_W          = 33;
    localparam int unsigned MAG_W           = 32;
    localparam int unsigned SQ_W            = 66;
    localparam int unsigned LEN_W           = 34;

    // Saturate a signed 66-bit value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sd2147483647;
            lo = -66'sd2147483648;
            if (v > hi)
                sat32 = 32'sh7fffffff;
            else if (v < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== rtl/pbd_distance_constraint_core.sv =====
//------------------------------------------------------------------------------
// pbd_distance_constraint_core: distance constraint correction pipeline
// Stages: 3 front stages, 33 root stages, 48 divider stages and 3 gain and
// product stages. The A result reaches the ports first; B follows in the
// cycle after. The intake blocks after each accepted start, since the
// result port carries two transfers per item; busy shows the blocked intake.
// Reset clears all valid bits and sets stiffness to 1.0; the receiver cannot stall.
//------------------------------------------------------------------------------
module pbd_distance_constraint_core #(
    parameter int unsigned FRAC_BITS   = pbd_pkg::FRAC_BITS_DEF,
    parameter int unsigned POINT_COUNT = pbd_pkg::POINT_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [16:0]         cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic [15:0]         point_a_index,
    input  logic [15:0]         point_b_index,
    input  logic signed [31:0]  a_pos_x,
    input  logic signed [31:0]  a_pos_y,
    input  logic signed [31:0]  a_pos_z,
    input  logic signed [31:0]  b_pos_x,
    input  logic signed [31:0]  b_pos_y,
    input  logic signed [31:0]  b_pos_z,
    input  logic [31:0]         inv_mass_a,
    input  logic [31:0]         inv_mass_b,
    input  logic [30:0]         rest_length,
    output logic                result_valid,
    output logic [15:0]         point_index,
    output logic signed [31:0]  delta_x,
    output logic signed [31:0]  delta_y,
    output logic signed [31:0]  delta_z,
    output logic                last
);
    // Indices are labels only; POINT_COUNT sets no storage in this design.
    localparam int unsigned IDX_BITS = (POINT_COUNT > 1) ? 16 : 16;
    localparam int unsigned F     = FRAC_BITS;
    // Share dividend wA << F, 32+F bits; direction dividend |d| << F.
    localparam int unsigned SH_NW = 32 + F;
    localparam int unsigned U_NW  = 32 + F;

    // Stiffness register, clamped at the point of use.
    logic [16:0] stiff_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stiff_reg <= pbd_pkg::STIFF_RESET;
        else if (cfg_we)
            stiff_reg <= cfg_wdata;
    end
    logic [16:0] stf;
    assign stf = (stiff_reg > pbd_pkg::STIFF_ONE) ? pbd_pkg::STIFF_ONE : stiff_reg;

    // Intake alternates: after a transfer the next cycle is blocked, which
    // matches the two result transfers that each item makes at the output.
    logic busy_reg;
    logic accept;
    assign busy   = busy_reg;
    assign accept = start && !busy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= accept;
    end

    // Stage 1: differences and their magnitudes.
    typedef struct packed {
        logic [15:0] ia;
        logic [15:0] ib;
        logic [2:0]  neg;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] mz;
        logic [31:0] wa;
        logic [31:0] wb;
        logic [30:0] rest;
    } s1_t;

    logic s1_valid_reg;
    s1_t  s1_reg;
    s1_t  s1_next;
    always_comb
    begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        dx = {a_pos_x[31], a_pos_x} - {b_pos_x[31], b_pos_x};
        dy = {a_pos_y[31], a_pos_y} - {b_pos_y[31], b_pos_y};
        dz = {a_pos_z[31], a_pos_z} - {b_pos_z[31], b_pos_z};
        s1_next.ia   = point_a_index[IDX_BITS-1:0];
        s1_next.ib   = point_b_index;
        s1_next.neg  = {dz[32], dy[32], dx[32]};
        s1_next.mx   = dx[32] ? 32'(-dx) : dx[31:0];
        s1_next.my   = dy[32] ? 32'(-dy) : dy[31:0];
        s1_next.mz   = dz[32] ? 32'(-dz) : dz[31:0];
        s1_next.wa   = inv_mass_a;
        s1_next.wb   = inv_mass_b;
        s1_next.rest = rest_length;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // Stage 2: squares, one 32x32 multiplier per axis.
    logic        s2_valid_reg;
    s1_t         s2_reg;
    logic [63:0] sqx_reg, sqy_reg, sqz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end
    always_ff @(posedge clk)
    begin
        s2_reg  <= s1_reg;
        sqx_reg <= s1_reg.mx * s1_reg.mx;
        sqy_reg <= s1_reg.my * s1_reg.my;
        sqz_reg <= s1_reg.mz * s1_reg.mz;
    end

    // Stage 3: sum of squares, then the root pipeline.
    logic                s3_valid_reg;
    s1_t                 s3_reg;
    logic [65:0]         sum_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end
    always_ff @(posedge clk)
    begin
        s3_reg  <= s2_reg;
        sum_reg <= 66'(sqx_reg) + 66'(sqy_reg) + 66'(sqz_reg);
    end

    logic        sq_valid;
    logic [33:0] len;
    s1_t         sq_data;
    pbd_sqrt #(.DATA_W($bits(s1_t))) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .radicand  (sum_reg),
        .data_in   (s3_reg),
        .out_valid (sq_valid),
        .root      (len),
        .data_out  (sq_data)
    );

    // Five dividers in parallel: two mass shares and three direction components.
    // The side tag of the first one carries everything later stages need.
    typedef struct packed {
        logic [15:0] ia;
        logic [15:0] ib;
        logic [2:0]  neg;
        logic        active;
        logic signed [35:0] stretch;
    } dv_t;

    dv_t         dv_in;
    logic [32:0] wsum;
    always_comb
    begin
        wsum          = 33'(sq_data.wa) + 33'(sq_data.wb);
        dv_in.ia      = sq_data.ia;
        dv_in.ib      = sq_data.ib;
        dv_in.neg     = sq_data.neg;
        dv_in.active  = (wsum != '0) && (len != '0);
        dv_in.stretch = $signed({2'b00, len}) - $signed({5'b0, sq_data.rest});
    end

    logic [SH_NW-1:0] sha, shb;
    logic [U_NW-1:0]  ux, uy, uz;
    logic             dv_valid;
    dv_t              dv_out;
    logic             v1, v2, v3, v4;
    logic [0:0]       t1, t2, t3, t4;

    // A zero divisor only occurs on inactive items, whose results are forced to zero.
    pbd_divider #(.NUM_W(SH_NW), .DEN_W(33), .TAG_W($bits(dv_t))) u_div_sa (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
        .num({sq_data.wa, F'(0)}), .den(wsum), .tag_in(dv_in),
        .out_valid(dv_valid), .quot(sha), .tag_out(dv_out));
    pbd_divider #(.NUM_W(SH_NW), .DEN_W(33), .TAG_W(1)) u_div_sb (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
        .num({sq_data.wb, F'(0)}), .den(wsum), .tag_in(1'b0),
        .out_valid(v1), .quot(shb), .tag_out(t1));
    pbd_divider #(.NUM_W(U_NW), .DEN_W(34), .TAG_W(1)) u_div_ux (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
        .num({sq_data.mx, F'(0)}), .den(len), .tag_in(1'b0),
        .out_valid(v2), .quot(ux), .tag_out(t2));
    pbd_divider #(.NUM_W(U_NW), .DEN_W(34), .TAG_W(1)) u_div_uy (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
        .num({sq_data.my, F'(0)}), .den(len), .tag_in(1'b0),
        .out_valid(v3), .quot(uy), .tag_out(t3));
    pbd_divider #(.NUM_W(U_NW), .DEN_W(34), .TAG_W(1)) u_div_uz (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid),
        .num({sq_data.mz, F'(0)}), .den(len), .tag_in(1'b0),
        .out_valid(v4), .quot(uz), .tag_out(t4));

    // Shares are at most 1.0, so F+1 bits hold them; unit components likewise.
    // Stage G: gains k = stf * share >> 16.
    logic         g_valid_reg;
    dv_t          g_reg;
    logic [F:0]   ka_reg, kb_reg;
    logic [F:0]   ux_reg, uy_reg, uz_reg;
    logic [17+F:0] pa, pb;
    assign pa = stf * sha[F:0];
    assign pb = stf * shb[F:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else
            g_valid_reg <= dv_valid;
    end
    always_ff @(posedge clk)
    begin
        g_reg  <= dv_out;
        ka_reg <= pa[16+F:16];
        kb_reg <= pb[16+F:16];
        ux_reg <= ux[F:0];
        uy_reg <= uy[F:0];
        uz_reg <= uz[F:0];
    end

    // Stage M: scaled stretch magnitudes m = |s| * k >> F.
    logic         m_valid_reg;
    dv_t          m_reg;
    logic [35+F:0] mpa, mpb;
    logic [35:0]  sabs;
    logic [35:0]  ma_reg, mb_reg;
    logic [F:0]   mux_reg, muy_reg, muz_reg;
    assign sabs = g_reg.stretch[35] ? 36'(-g_reg.stretch) : 36'(g_reg.stretch);
    assign mpa  = (36+F)'(sabs) * ka_reg;
    assign mpb  = (36+F)'(sabs) * kb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= g_valid_reg;
    end
    always_ff @(posedge clk)
    begin
        m_reg   <= g_reg;
        ma_reg  <= 36'(mpa >> F);
        mb_reg  <= 36'(mpb >> F);
        mux_reg <= ux_reg;
        muy_reg <= uy_reg;
        muz_reg <= uz_reg;
    end

    // Stage P: six products |m| * |u| >> F, then sign and saturate.
    logic         p_valid_reg;
    dv_t          p_reg;
    logic signed [31:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;

    function automatic logic signed [31:0] corr(
        input logic [35:0] m, input logic [F:0] u, input logic neg);
        logic [36+F:0]      p;
        logic signed [65:0] v;
        begin
            p = (37+F)'(m) * u;
            v = $signed(66'(p >> F));
            if (neg)
                v = -v;
            corr = pbd_pkg::sat32(v);
        end
    endfunction

    // A moves against the stretch: negate when sign(s) == sign(d_i).
    logic sn;
    assign sn = m_reg.stretch[35];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= m_valid_reg;
    end
    always_ff @(posedge clk)
    begin
        p_reg  <= m_reg;
        ax_reg <= corr(ma_reg, mux_reg, !(sn ^ m_reg.neg[0]));
        ay_reg <= corr(ma_reg, muy_reg, !(sn ^ m_reg.neg[1]));
        az_reg <= corr(ma_reg, muz_reg, !(sn ^ m_reg.neg[2]));
        bx_reg <= corr(mb_reg, mux_reg, sn ^ m_reg.neg[0]);
        by_reg <= corr(mb_reg, muy_reg, sn ^ m_reg.neg[1]);
        bz_reg <= corr(mb_reg, muz_reg, sn ^ m_reg.neg[2]);
    end

    // Output: A result in the cycle after stage P, B result in the next one.
    // The intake never accepts items back to back, so the B slot never collides.
    logic               out_v_reg, last_reg;
    logic [15:0]        idx_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               hold_reg;
    logic [15:0]        hidx_reg;
    logic signed [31:0] hx_reg, hy_reg, hz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            hold_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            out_v_reg <= p_valid_reg || hold_reg;
            last_reg  <= !p_valid_reg && hold_reg;
            hold_reg  <= p_valid_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            idx_reg  <= p_reg.ia;
            ox_reg   <= p_reg.active ? ax_reg : '0;
            oy_reg   <= p_reg.active ? ay_reg : '0;
            oz_reg   <= p_reg.active ? az_reg : '0;
            hidx_reg <= p_reg.ib;
            hx_reg   <= p_reg.active ? bx_reg : '0;
            hy_reg   <= p_reg.active ? by_reg : '0;
            hz_reg   <= p_reg.active ? bz_reg : '0;
        end
        else
        begin
            idx_reg <= hidx_reg;
            ox_reg  <= hx_reg;
            oy_reg  <= hy_reg;
            oz_reg  <= hz_reg;
        end
    end

    assign result_valid = out_v_reg;
    assign point_index  = idx_reg;
    assign delta_x      = ox_reg;
    assign delta_y      = oy_reg;
    assign delta_z      = oz_reg;
    assign last         = last_reg;

    // Two back-to-back intakes can never occur.
    a_no_double_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !accept)
        else $error("intake accepted in consecutive cycles");

    // Every A result is followed by a B result.
    a_b_follows_a: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> (result_valid && last))
        else $error("B result missing after A result");

    // A B result always follows an A result.
    a_a_before_b: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> $past(result_valid && !last))
        else $error("B result without preceding A result");

    // Parallel dividers stay in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid == v1 && v1 == v2 && v2 == v3 && v3 == v4)
        else $error("divider valid bits out of step");
endmodule

// ===== rtl/pbd_divider.sv =====
//------------------------------------------------------------------------------
// pbd_divider: pipelined restoring divider
// One quotient bit per stage; a valid bit and a side tag travel with the data.
//------------------------------------------------------------------------------
module pbd_divider #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 34,
    parameter int unsigned TAG_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    input  logic [TAG_W-1:0]     tag_in,
    output logic                 out_valid,
    output logic [NUM_W-1:0]     quot,
    output logic [TAG_W-1:0]     tag_out
);
    logic [NUM_W:0]              valid_reg;
    logic [NUM_W-1:0]            q_reg   [NUM_W+1];
    logic [DEN_W:0]              rem_reg [NUM_W+1];
    logic [DEN_W-1:0]            den_reg [NUM_W+1];
    logic [TAG_W-1:0]            tag_reg [NUM_W+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        q_reg[0]     = num;
        rem_reg[0]   = '0;
        den_reg[0]   = den;
        tag_reg[0]   = tag_in;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W+1:0] trial;
        logic [DEN_W:0]   rem_next;
        logic [NUM_W-1:0] q_next;
        always_comb
        begin
            trial = {rem_reg[s], q_reg[s][NUM_W-1]} - {2'b00, den_reg[s]};
            if (!trial[DEN_W+1])
            begin
                rem_next = trial[DEN_W:0];
                q_next   = {q_reg[s][NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[s][DEN_W-1:0], q_reg[s][NUM_W-1]};
                q_next   = {q_reg[s][NUM_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else
                valid_reg[s+1] <= valid_reg[s];
        end
        always_ff @(posedge clk)
        begin
            q_reg[s+1]   <= q_next;
            rem_reg[s+1] <= rem_next;
            den_reg[s+1] <= den_reg[s];
            tag_reg[s+1] <= tag_reg[s];
        end
    end

    assign out_valid = valid_reg[NUM_W];
    assign quot      = q_reg[NUM_W];
    assign tag_out   = tag_reg[NUM_W];
endmodule

// ===== rtl/pbd_sqrt.sv =====
//------------------------------------------------------------------------------
// pbd_sqrt: pipelined integer square root
// One result bit per stage over a 66-bit radicand; data rides alongside.
//------------------------------------------------------------------------------
module pbd_sqrt #(
    parameter int unsigned DATA_W = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [pbd_pkg::SQ_W-1:0]       radicand,
    input  logic [DATA_W-1:0]              data_in,
    output logic                           out_valid,
    output logic [pbd_pkg::LEN_W-1:0]      root,
    output logic [DATA_W-1:0]              data_out
);
    localparam int unsigned N  = pbd_pkg::LEN_W;
    localparam int unsigned S  = pbd_pkg::SQ_W;
    // Two radicand bits per stage, so half as many stages as radicand bits.
    localparam int unsigned NS = S / 2;

    logic [NS:0]     valid_reg;
    logic [N-1:0]    root_reg [NS+1];
    logic [S+1:0]    rem_reg  [NS+1];
    logic [S-1:0]    rad_reg  [NS+1];
    logic [DATA_W-1:0] dat_reg [NS+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        root_reg[0]  = '0;
        rem_reg[0]   = '0;
        rad_reg[0]   = radicand;
        dat_reg[0]   = data_in;
    end

    // Digit-by-digit method: bring down two radicand bits per stage.
    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [S+1:0] cur;
        logic [S+1:0] trial;
        logic [S+1:0] sub;
        logic [S+1:0] rem_next;
        logic [N-1:0] root_next;
        always_comb
        begin
            cur   = {rem_reg[s][S-1:0], rad_reg[s][S-1:S-2]};
            sub   = {{(S+2-N-2){1'b0}}, root_reg[s], 2'b01};
            trial = cur - sub;
            if (cur >= sub)
            begin
                rem_next  = trial;
                root_next = {root_reg[s][N-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_reg[s][N-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else
                valid_reg[s+1] <= valid_reg[s];
        end
        always_ff @(posedge clk)
        begin
            root_reg[s+1] <= root_next;
            rem_reg[s+1]  <= rem_next;
            rad_reg[s+1]  <= {rad_reg[s][S-3:0], 2'b00};
            dat_reg[s+1]  <= dat_reg[s];
        end
    end

    assign out_valid = valid_reg[NS];
    assign root      = root_reg[NS];
    assign data_out  = dat_reg[NS];
endmodule
